[rtl/uniform_range_encoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// Uniform range encoder assertion macros
// Shorthand for clocked implication checks used by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_RANGE_ENCODER_UNIT_MACROS_SVH
`define UNIFORM_RANGE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define URE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define URE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ure_pkg.sv]
// ----------------------------------------------------------------------------
// Uniform range encoder package
// Shared widths, constants and the sequencer state type.
// ----------------------------------------------------------------------------
package ure_pkg;

    localparam int WORD_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int RADIX_W = 9;
    localparam int QCNT_W  = 6;
    localparam int MAX_OUT = 8;
    localparam int NCNT_W  = 4;
    localparam int BUF_AW  = 3;
    localparam int BAE_W   = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd64;
    localparam logic [RADIX_W-1:0] RADIX_PASS  = 9'd256;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_LOAD   = 9'b000000010,
        ST_MUL    = 9'b000000100,
        ST_ADD    = 9'b000001000,
        ST_DIV0   = 9'b000010000,
        ST_DIV1   = 9'b000100000,
        ST_UPD    = 9'b001000000,
        ST_RENORM = 9'b010000000,
        ST_DRAIN  = 9'b100000000
    } ure_state_t;

endpackage

[rtl/ure_div.sv]
// ----------------------------------------------------------------------------
// Uniform range encoder divider
// Restoring radix-2 divider: 64-bit dividend by radix, one quotient bit/cycle.
// ----------------------------------------------------------------------------
module ure_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ure_pkg::WORD_W-1:0]    dividend,
    input  logic [ure_pkg::RADIX_W-1:0]   divisor,
    output logic                          done,
    output logic [ure_pkg::WORD_W-1:0]    quotient
);
    import ure_pkg::*;

    logic [WORD_W-1:0]  dvd_reg;
    logic [RADIX_W-1:0] rem_reg;
    logic [RADIX_W-1:0] dsr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [RADIX_W:0]   trial;
    logic               ge;
    logic [RADIX_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCNT_W'(WORD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops
            rem_reg <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
            dvd_reg <= {dvd_reg[WORD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[rtl/uniform_range_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Uniform range encoder unit
// Carry-less range coder with equal symbol weights, packing symbols to bytes.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake             Payload
// s_        in   s_tvalid/s_tready     tdata=symbol, tlast=last
// m_        out  m_tvalid/m_tready     tdata=out_byte, tlast=run_last,
//                                      tuser={invalid, message_end}
// cfg_      in   cfg_we                cfg_wdata=radix
//
// A coded symbol is loaded, multiplied, summed, divided in two passes of the
// shared bit-serial divider and renormalised; each byte is shifted out in
// renormalisation, then drained. A final symbol repeats the narrowing for
// each phantom symbol until the tail bytes are out. Pass-through and
// invalid symbols skip to draining. Results drain from an eight-byte buffer
// through one output register, one per accepted transaction; a stalled output
// holds the input. Synchronous active-low reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uniform_range_encoder_unit #(
    parameter int SHIFT_BITS = 48
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser,   // [0] message_end, [1] invalid
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata
);
    import ure_pkg::*;

    `include "uniform_range_encoder_unit_macros.svh"

    localparam logic [WORD_W-1:0] TOP_ONES  = (64'd1 << (SHIFT_BITS + 8)) - 64'd1;
    localparam logic [WORD_W-1:0] LOW_MASK  = (64'd1 << SHIFT_BITS) - 64'd1;
    localparam int                AFTER_END = (SHIFT_BITS + 7) / 8 + 1;

    ure_state_t          state_reg;
    logic [RADIX_W-1:0]  radix_reg;
    logic [WORD_W-1:0]   high_reg;
    logic [WORD_W-1:0]   low_reg;
    logic [WORD_W-1:0]   denom_reg;
    logic [WORD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]   num0_reg;
    logic [WORD_W-1:0]   num1_reg;
    logic [WORD_W-1:0]   q0_reg;
    logic [RADIX_W-1:0]  m_reg;
    logic [BYTE_W-1:0]   c_reg;
    logic                ending_reg;
    logic [BAE_W-1:0]    bae_reg;
    logic [NCNT_W-1:0]   n_reg;
    logic [NCNT_W-1:0]   idx_reg;
    logic                end_flag_reg;
    logic                inv_flag_reg;
    logic                div_run_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;
    logic [1:0]          out_user_reg;
    logic [BYTE_W-1:0]   buf_mem [MAX_OUT];

    logic [RADIX_W-1:0]  eff_radix;
    logic [WORD_W-1:0]   m1;
    logic                s_acc;
    logic                div_start;
    logic                div_done;
    logic [WORD_W-1:0]   div_quot;
    logic [WORD_W-1:0]   div_dvd;
    logic                agree;
    logic                narrow;
    logic                emit;
    logic                bae_done;
    logic                out_free;
    logic                drain_last;
    logic                buf_we;
    logic [BUF_AW-1:0]   buf_wa;
    logic [BYTE_W-1:0]   buf_wd;

    always_comb begin
        if (radix_reg == '0 || radix_reg > RADIX_PASS) begin
            eff_radix = RADIX_PASS;
        end else if (radix_reg == 9'd1) begin
            eff_radix = RADIX_MIN;
        end else begin
            eff_radix = radix_reg;
        end
    end

    assign m1        = {{(WORD_W-RADIX_W){1'b0}}, m_reg} - 64'd1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign div_start = (state_reg == ST_DIV0 || state_reg == ST_DIV1) && !div_run_reg;
    assign div_dvd   = (state_reg == ST_DIV0) ? num0_reg : num1_reg;

    ure_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (m_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign agree    = (((high_reg ^ low_reg) >> SHIFT_BITS) == '0);
    assign narrow   = (high_reg < low_reg + m1);
    assign emit     = (agree || narrow) && (n_reg < NCNT_W'(MAX_OUT));
    assign bae_done = ({1'b0, bae_reg} + 4'd1) >= 4'(AFTER_END);
    assign out_free = !out_valid_reg || m_tready;
    assign drain_last = (idx_reg == n_reg - 1'b1);

    // buffer write port
    always_comb begin
        buf_we = 1'b0;
        buf_wa = n_reg[BUF_AW-1:0];
        buf_wd = low_reg[SHIFT_BITS +: BYTE_W];
        if (s_acc) begin
            buf_we = 1'b1;
            buf_wa = '0;
            buf_wd = (eff_radix == RADIX_PASS) ? s_tdata : '0;
        end else if (state_reg == ST_RENORM && emit) begin
            buf_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_wa] <= buf_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_we) begin
            radix_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_DRAIN && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            high_reg      <= TOP_ONES;
            low_reg       <= '0;
            ending_reg    <= 1'b0;
            bae_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            div_run_reg   <= 1'b0;
        end else begin
            if (div_start) begin
                div_run_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (s_acc) begin
                        if (eff_radix == RADIX_PASS) begin
                            n_reg        <= NCNT_W'(1);
                            end_flag_reg <= s_tlast;
                            inv_flag_reg <= 1'b0;
                            state_reg    <= ST_DRAIN;
                        end else if ({1'b0, s_tdata} >= eff_radix) begin
                            n_reg        <= NCNT_W'(1);
                            end_flag_reg <= 1'b1;
                            inv_flag_reg <= 1'b1;
                            high_reg     <= TOP_ONES;
                            low_reg      <= '0;
                            state_reg    <= ST_DRAIN;
                        end else begin
                            c_reg        <= s_tdata;
                            m_reg        <= eff_radix;
                            ending_reg   <= s_tlast;
                            end_flag_reg <= s_tlast;
                            inv_flag_reg <= 1'b0;
                            bae_reg      <= '0;
                            n_reg        <= '0;
                            state_reg    <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    denom_reg <= high_reg - low_reg + 64'd1;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= denom_reg * {{(WORD_W-BYTE_W){1'b0}}, c_reg};
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    num0_reg  <= prod_reg + m1;
                    num1_reg  <= prod_reg + denom_reg + m1;
                    state_reg <= ST_DIV0;
                end
                ST_DIV0: begin
                    if (div_done) begin
                        q0_reg      <= div_quot;
                        div_run_reg <= 1'b0;
                        state_reg   <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        high_reg    <= low_reg + div_quot - 64'd1;
                        low_reg     <= low_reg + q0_reg;
                        div_run_reg <= 1'b0;
                        state_reg   <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    state_reg <= ST_RENORM;
                end
                ST_RENORM: begin
                    if (emit) begin
                        n_reg <= n_reg + 1'b1;
                        if (ending_reg && bae_done) begin
                            // tail complete: drop the interval for the next message
                            high_reg   <= TOP_ONES;
                            low_reg    <= '0;
                            bae_reg    <= '0;
                            ending_reg <= 1'b0;
                            state_reg  <= ST_DRAIN;
                        end else begin
                            high_reg <= ((high_reg & LOW_MASK) << 8) | 64'hFF;
                            low_reg  <= (low_reg & LOW_MASK) << 8;
                            if (ending_reg) begin
                                bae_reg <= bae_reg + 1'b1;
                            end
                        end
                    end else if (!ending_reg || n_reg >= NCNT_W'(MAX_OUT)) begin
                        if (ending_reg) begin
                            high_reg   <= TOP_ONES;
                            low_reg    <= '0;
                            ending_reg <= 1'b0;
                        end
                        state_reg <= (n_reg == '0) ? ST_IDLE : ST_DRAIN;
                    end else begin
                        // feed a phantom midpoint symbol
                        c_reg     <= m_reg[RADIX_W-1:1];
                        state_reg <= ST_LOAD;
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        out_byte_reg  <= buf_mem[idx_reg[BUF_AW-1:0]];
                        out_last_reg  <= drain_last;
                        out_user_reg  <= {inv_flag_reg, end_flag_reg & drain_last};
                        idx_reg       <= idx_reg + 1'b1;
                        if (drain_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    `URE_ASSERT_IMP(a_n_cap, state_reg == ST_RENORM, n_reg <= NCNT_W'(MAX_OUT), "byte count over cap")
    `URE_ASSERT_IMP(a_end_on_last, m_tvalid && m_tuser[0], m_tlast, "message end off run last")
    `URE_ASSERT_IMP(a_inv_ends, m_tvalid && m_tuser[1], m_tuser[0] && m_tlast, "invalid not final")
    `URE_ASSERT_IMP(a_div_state, div_done, state_reg == ST_DIV0 || state_reg == ST_DIV1, "stray divide done")
    `URE_ASSERT_NXT(a_drain_idle, state_reg == ST_DRAIN && out_free && drain_last, state_reg == ST_IDLE, "drain did not finish")

endmodule
